[hw/rtl/dls_pkg.sv]
// Shared types, constants and the sigmoid table for the dense sigmoid layer.
`timescale 1ns / 1ps

package dls_pkg;

  localparam int MAX_INPUTS_DEF  = 256;
  localparam int MAX_OUTPUTS_DEF = 64;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_ACT    = 2'd2;

  localparam logic REG_INPUTS  = 1'b0;
  localparam logic REG_OUTPUTS = 1'b1;

  localparam logic [8:0] INPUTS_RESET  = 9'd256;
  localparam logic [6:0] OUTPUTS_RESET = 7'd64;

  localparam logic [12:0] ONE_Q12      = 13'd4096;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748383;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         neuron;
    logic [7:0]         position;
    logic signed [15:0] value;
    logic               final_req;
  } req_t;

  typedef struct packed {
    logic [5:0]  out_index;
    logic [12:0] activation;
    logic        out_last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last_in;
    logic       last_out;
    logic [5:0] neuron;
  } issue_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } run_state_t;

  typedef logic [255:0][12:0] sig_table_t;

  // e^(-k/16) by repeated rounded products, then 4096 / (1 + e^(-k/16)) rounded,
  // the quotient by shift-and-subtract.
  function automatic sig_table_t build_sig_table();
    sig_table_t   t;
    logic [12:0]  s [129];
    logic [127:0] p;
    logic [127:0] prod;
    logic [63:0]  d;
    logic [63:0]  num;
    logic [63:0]  rem;
    logic [63:0]  q;
    p = 128'd1 << 32;
    for (int k = 0; k <= 128; k++) begin
      d   = (64'd1 << 32) + p[63:0];
      num = (64'd1 << 44) + (d >> 1);
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
      s[k] = q[12:0];
      prod = p * {64'd0, EXP_STEP_Q32} + (128'd1 << 31);
      p    = prod >> 32;
    end
    for (int k = 0; k < 256; k++) begin
      if (k >= 128) t[k] = s[k - 128];
      else          t[k] = ONE_Q12 - s[128 - k];
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

[hw/rtl/dls_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module dls_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dls_ctrl.sv]
// Load decode, run sequencer and address generation.
`timescale 1ns / 1ps

module dls_ctrl import dls_pkg::*; #(
  parameter int  MAX_INPUTS  = MAX_INPUTS_DEF,
  parameter int  MAX_OUTPUTS = MAX_OUTPUTS_DEF,
  localparam int IW = $clog2(MAX_INPUTS),
  localparam int NW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1,
  localparam int WA = $clog2(MAX_INPUTS * MAX_OUTPUTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  req_t          req,
  output logic          busy,
  input  logic [8:0]    inputs_in_use,
  input  logic [6:0]    outputs_in_use,
  input  logic          run_done,
  output logic [15:0]   wdata,
  output logic          w_we,
  output logic [WA-1:0] w_waddr,
  output logic [WA-1:0] w_raddr,
  output logic          b_we,
  output logic [NW-1:0] b_waddr,
  output logic [NW-1:0] b_raddr,
  output logic          a_we,
  output logic [IW-1:0] a_waddr,
  output logic [IW-1:0] a_raddr,
  output issue_t        tag
);

  run_state_t    state, state_next;
  logic [IW-1:0] in_cnt, in_cnt_next;
  logic [NW-1:0] out_cnt, out_cnt_next;
  logic [WA-1:0] wbase, wbase_next;
  logic [IW-1:0] last_in, last_in_next;
  logic [NW-1:0] last_out, last_out_next;
  logic          accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign wdata   = req.value;
  assign w_we    = accept && (req.req_type == REQ_WEIGHT) &&
                   (int'(req.neuron) < MAX_OUTPUTS) && (int'(req.position) < MAX_INPUTS);
  assign w_waddr = WA'(int'(req.neuron) * MAX_INPUTS + int'(req.position));
  assign b_we    = accept && (req.req_type == REQ_BIAS) && (int'(req.neuron) < MAX_OUTPUTS);
  assign b_waddr = NW'(req.neuron);
  assign a_we    = accept && (req.req_type == REQ_ACT) && (int'(req.position) < MAX_INPUTS);
  assign a_waddr = IW'(req.position);

  assign w_raddr = wbase + WA'(in_cnt);
  assign a_raddr = in_cnt;
  assign b_raddr = out_cnt;

  assign tag.valid    = (state == ST_ISSUE);
  assign tag.first    = (in_cnt == '0);
  assign tag.last_in  = (in_cnt == last_in);
  assign tag.last_out = (out_cnt == last_out);
  assign tag.neuron   = 6'(out_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    in_cnt   <= in_cnt_next;
    out_cnt  <= out_cnt_next;
    wbase    <= wbase_next;
    last_in  <= last_in_next;
    last_out <= last_out_next;
  end

  always_comb begin
    int li;
    int lo;
    li = int'(inputs_in_use);
    if (li < 1) li = 1;
    if (li > MAX_INPUTS) li = MAX_INPUTS;
    lo = int'(outputs_in_use);
    if (lo < 1) lo = 1;
    if (lo > MAX_OUTPUTS) lo = MAX_OUTPUTS;
    state_next    = state;
    in_cnt_next   = in_cnt;
    out_cnt_next  = out_cnt;
    wbase_next    = wbase;
    last_in_next  = last_in;
    last_out_next = last_out;
    case (state)
      ST_IDLE: begin
        if (accept && (req.req_type == REQ_ACT) && req.final_req) begin
          state_next    = ST_ISSUE;
          in_cnt_next   = '0;
          out_cnt_next  = '0;
          wbase_next    = '0;
          last_in_next  = IW'(li - 1);
          last_out_next = NW'(lo - 1);
        end
      end
      ST_ISSUE: begin
        if (in_cnt == last_in) begin
          in_cnt_next  = '0;
          out_cnt_next = out_cnt + 1'b1;
          wbase_next   = wbase + WA'(MAX_INPUTS);
          if (out_cnt == last_out) state_next = ST_DRAIN;
        end else begin
          in_cnt_next = in_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (run_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/dls_mac.sv]
// Multiply-accumulate pipeline, sigmoid lookup and result register.
`timescale 1ns / 1ps

module dls_mac import dls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  issue_t      tag,
  input  logic [15:0] w_rdata,
  input  logic [15:0] a_rdata,
  input  logic [15:0] b_rdata,
  output logic        result_valid,
  output result_t     result
);

  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

  issue_t             tag_d1, tag_d2, tag_d3;
  logic signed [31:0] prod;
  logic signed [15:0] bias_q;
  logic signed [47:0] acc;
  logic signed [47:0] acc_base;
  logic signed [48:0] sum;
  logic signed [47:0] acc_next;
  logic               in_range;
  logic [7:0]         tbl_idx;
  logic [12:0]        act;

  always_comb begin
    acc_base = tag_d2.first ? (48'(bias_q) <<< 12) : acc;
    sum      = {acc_base[47], acc_base} + 49'(prod);
    if (sum[48] != sum[47]) acc_next = sum[48] ? ACC_MIN : ACC_MAX;
    else                    acc_next = sum[47:0];
  end

  // z = acc >> 12 fits 16 bits when acc[47:27] is a pure sign extension
  assign in_range = (&acc[47:27]) || !(|acc[47:27]);
  assign tbl_idx  = {~acc[27], acc[26:20]};

  always_comb begin
    if (in_range)    act = SIG_TABLE[tbl_idx];
    else if (acc[47]) act = '0;
    else             act = ONE_Q12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d1.valid <= 1'b0;
      tag_d2.valid <= 1'b0;
      tag_d3.valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      tag_d1       <= tag;
      tag_d2       <= tag_d1;
      tag_d3       <= tag_d2;
      result_valid <= tag_d3.valid && tag_d3.last_in;
    end
    prod   <= $signed(w_rdata) * $signed(a_rdata);
    bias_q <= $signed(b_rdata);
    if (tag_d2.valid) acc <= acc_next;
    result.out_index  <= tag_d3.neuron;
    result.activation <= act;
    result.out_last   <= tag_d3.last_out;
  end

endmodule

[hw/rtl/dense_layer_sigmoid_forward.sv]
// Load items (weight, bias, activation element) are written when accepted; busy stays low.
// The final activation element starts a run: one MAC per cycle through the single
// weight RAM read port, one result per neuron after its last input, the last result
// ending the run, busy high until then. Results cannot be stalled.
// Synchronous reset clears the sequencer and sets inputs_in_use 256, outputs_in_use
// 64; weight, bias and activation RAMs are undefined until written.
`timescale 1ns / 1ps

module dense_layer_sigmoid_forward import dls_pkg::*; #(
  parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_INPUTS);
  localparam int NW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int WA = $clog2(MAX_INPUTS * MAX_OUTPUTS);

  logic [8:0]    inputs_in_use;
  logic [6:0]    outputs_in_use;
  logic [15:0]   wdata;
  logic          w_we, b_we, a_we;
  logic [WA-1:0] w_waddr, w_raddr;
  logic [NW-1:0] b_waddr, b_raddr;
  logic [IW-1:0] a_waddr, a_raddr;
  logic [15:0]   w_rdata, b_rdata, a_rdata;
  issue_t        tag;
  logic          run_done;

  assign pready   = 1'b1;
  assign run_done = result_valid && result.out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use  <= INPUTS_RESET;
      outputs_in_use <= OUTPUTS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_INPUTS:  inputs_in_use  <= pwdata[8:0];
        REG_OUTPUTS: outputs_in_use <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INPUTS:  prdata = {23'd0, inputs_in_use};
      REG_OUTPUTS: prdata = {25'd0, outputs_in_use};
      default:     prdata = '0;
    endcase
  end

  dls_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .req            (req),
    .busy           (busy),
    .inputs_in_use  (inputs_in_use),
    .outputs_in_use (outputs_in_use),
    .run_done       (run_done),
    .wdata          (wdata),
    .w_we           (w_we),
    .w_waddr        (w_waddr),
    .w_raddr        (w_raddr),
    .b_we           (b_we),
    .b_waddr        (b_waddr),
    .b_raddr        (b_raddr),
    .a_we           (a_we),
    .a_waddr        (a_waddr),
    .a_raddr        (a_raddr),
    .tag            (tag)
  );

  dls_ram #(
    .WIDTH (16),
    .DEPTH (MAX_INPUTS * MAX_OUTPUTS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  dls_ram #(
    .WIDTH (16),
    .DEPTH (MAX_OUTPUTS)
  ) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  dls_ram #(
    .WIDTH (16),
    .DEPTH (MAX_INPUTS)
  ) u_act_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dls_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .tag          (tag),
    .w_rdata      (w_rdata),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the dense sigmoid layer: loads, runs, register sweeps, scoreboard.
`timescale 1ns / 1ps

module tb;
  import dls_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  class layer_checker;
    logic signed [15:0] weight_mem [MAX_OUTPUTS_DEF][MAX_INPUTS_DEF];
    logic signed [15:0] bias_mem [MAX_OUTPUTS_DEF];
    logic signed [15:0] act_mem [MAX_INPUTS_DEF];
    logic [12:0]        sig_lut [256];
    logic [8:0]         inputs_reg;
    logic [6:0]         outputs_reg;
    result_t            pending_activations [$];
    int                 errors;

    function new();
      longint unsigned p;
      longint unsigned d;
      logic [12:0]     half [129];
      inputs_reg  = INPUTS_RESET;
      outputs_reg = OUTPUTS_RESET;
      errors      = 0;
      p = 64'd1 << 32;
      for (int k = 0; k <= 128; k++) begin
        d       = (64'd1 << 32) + p;
        half[k] = 13'(((64'd1 << 44) + (d >> 1)) / d);
        p       = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      end
      for (int k = 0; k < 256; k++) begin
        if (k >= 128) sig_lut[k] = half[k - 128];
        else          sig_lut[k] = ONE_Q12 - half[128 - k];
      end
    endfunction

    function void set_register(logic idx, logic [31:0] v);
      if (idx == REG_INPUTS) inputs_reg = v[8:0];
      else                   outputs_reg = v[6:0];
    endfunction

    function int pending();
      return pending_activations.size();
    endfunction

    function logic [12:0] squash(longint acc);
      longint z;
      z = acc >>> 12;
      if (z < -32768) return 13'd0;
      if (z > 32767) return ONE_Q12;
      return sig_lut[int'((z + 32768) >>> 8)];
    endfunction

    function void apply_request(req_t r);
      int      ni;
      int      no;
      longint  acc;
      result_t want;
      case (r.req_type)
        REQ_WEIGHT: weight_mem[r.neuron][r.position] = r.value;
        REQ_BIAS: bias_mem[r.neuron] = r.value;
        REQ_ACT: begin
          act_mem[r.position] = r.value;
          if (r.final_req) begin
            ni = (inputs_reg == 0) ? 1 :
                 (inputs_reg > MAX_INPUTS_DEF) ? MAX_INPUTS_DEF : int'(inputs_reg);
            no = (outputs_reg == 0) ? 1 :
                 (outputs_reg > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF : int'(outputs_reg);
            for (int n = 0; n < no; n++) begin
              acc = longint'(bias_mem[n]) * 4096;
              for (int i = 0; i < ni; i++)
                acc += longint'(weight_mem[n][i]) * longint'(act_mem[i]);
              want.out_index  = 6'(n);
              want.activation = squash(acc);
              want.out_last   = (n == no - 1);
              pending_activations.push_back(want);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_activation(result_t got);
      result_t want;
      if (pending_activations.size() == 0) begin
        report_mismatch($sformatf("unexpected result, neuron %0d activation %0d",
                                  got.out_index, got.activation));
      end else begin
        want = pending_activations.pop_front();
        if (got.out_index !== want.out_index || got.activation !== want.activation ||
            got.out_last !== want.out_last)
          report_mismatch($sformatf("got n=%0d a=%0d l=%0b, wanted n=%0d a=%0d l=%0b",
                                    got.out_index, got.activation, got.out_last,
                                    want.out_index, want.activation, want.out_last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy;
  logic        result_valid;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  layer_checker sb = new();
  int sent = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  dense_layer_sigmoid_forward dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_activation(result);
      if (start && !busy) sb.apply_request(req);
    end
  end

  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [5:0] n, logic [7:0] p,
                                    logic signed [15:0] v, logic fin);
    req_t r;
    r.req_type  = kind;
    r.neuron    = n;
    r.position  = p;
    r.value     = v;
    r.final_req = fin;
    return r;
  endfunction

  // mostly within +-1.0 so that small sums land inside the table range
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic send(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sent++;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      req   <= make_req(2'($urandom), 6'($urandom), 8'($urandom), 16'($urandom),
                        1'($urandom));
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, data);
    @(posedge clk);
  endtask

  initial begin
    int ni;
    int no;
    int goal;
    int loads;
    int count;
    int p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fill the part of each store that the runs read: column 0 of every neuron,
    // an 8 by 8 corner of the weights, every bias and the first 8 elements
    for (int n = 0; n < MAX_OUTPUTS_DEF; n++)
      send(make_req(REQ_WEIGHT, 6'(n), 8'd0, pick_value(), 1'b0));
    for (int n = 0; n < 8; n++)
      for (int i = 1; i < 8; i++)
        send(make_req(REQ_WEIGHT, 6'(n), 8'(i), pick_value(), 1'b0));
    for (int n = 0; n < MAX_OUTPUTS_DEF; n++)
      send(make_req(REQ_BIAS, 6'(n), 8'($urandom), pick_value(), 1'b0));
    for (int i = 0; i < 8; i++)
      send(make_req(REQ_ACT, 6'($urandom), 8'(i), pick_value(), 1'b0));

    idle_pct = 25;

    wait_drained();
    apb_write(REG_INPUTS, 32'd1);
    apb_write(REG_OUTPUTS, 32'd1);
    send(make_req(REQ_WEIGHT, 6'd0, 8'd0, 16'sh7FFF, 1'b0));
    send(make_req(REQ_BIAS, 6'd0, 8'd0, 16'sh7FFF, 1'b0));
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'sh7FFF, 1'b1));
    // final mark on a weight write is ignored
    send(make_req(REQ_WEIGHT, 6'd0, 8'd0, 16'sh8000, 1'b1));
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'sh7FFF, 1'b1));
    // top and bottom table entries, just inside saturation
    send(make_req(REQ_WEIGHT, 6'd0, 8'd0, 16'sh0000, 1'b0));
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'shFFFF, 1'b1));
    send(make_req(REQ_BIAS, 6'd0, 8'd0, 16'sh8000, 1'b1));
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'sh0000, 1'b1));
    send(make_req(REQ_BIAS, 6'd0, 8'd0, 16'sh0000, 1'b0));
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'sh0005, 1'b1));
    // unknown request type, then loads at the far indexes
    send(make_req(2'd3, 6'd63, 8'd255, 16'sh7FFF, 1'b1));
    send(make_req(REQ_ACT, 6'd63, 8'd200, 16'sh8000, 1'b0));
    send(make_req(REQ_WEIGHT, 6'd63, 8'd255, 16'shFFFF, 1'b1));
    send(make_req(REQ_BIAS, 6'd63, 8'd255, 16'sh0007, 1'b0));
    // element outside the active range: run reuses the old vector
    send(make_req(REQ_ACT, 6'd0, 8'd255, 16'sh007B, 1'b1));

    wait_drained();
    apb_write(REG_INPUTS, 32'd0);
    apb_write(REG_OUTPUTS, 32'd0);
    send(make_req(REQ_ACT, 6'd0, 8'd0, 16'sh1000, 1'b1));

    wait_drained();
    apb_write(REG_INPUTS, 32'd1);
    apb_write(REG_OUTPUTS, 32'h7F);
    send(make_req(REQ_ACT, 6'd0, 8'd17, pick_value(), 1'b1));

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      idle_pct = (seg < 2) ? 25 : (seg < 4) ? 88 : 0;
      case (seg)
        1: begin ni = 8; no = 1;  end
        3: begin ni = 1; no = 64; end
        default: begin
          ni = $urandom_range(1, 8);
          no = $urandom_range(1, 8);
        end
      endcase
      apb_write(REG_INPUTS, 32'(ni));
      apb_write(REG_OUTPUTS, 32'(no));
      goal = sent + 40;
      while (sent < goal) begin
        if ($urandom_range(0, 99) < 80) begin
          loads = $urandom_range(0, 4);
          repeat (loads) begin
            if ($urandom_range(0, 1) != 0)
              send(make_req(REQ_WEIGHT, 6'($urandom_range(0, no - 1)),
                            8'($urandom_range(0, ni - 1)), pick_value(), 1'($urandom)));
            else
              send(make_req(REQ_BIAS, 6'($urandom_range(0, no - 1)), 8'($urandom),
                            pick_value(), 1'($urandom)));
          end
          count = (ni <= 16) ? ni : 8;
          for (int k = 0; k < count; k++) begin
            p = (ni <= 16) ? k : $urandom_range(0, ni - 1);
            send(make_req(REQ_ACT, 6'($urandom), 8'(p), pick_value(), k == count - 1));
          end
        end else begin
          send(make_req(2'($urandom), 6'($urandom), 8'($urandom), 16'($urandom),
                        1'($urandom)));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

[dense_layer_sigmoid_forward.f]
hw/rtl/dls_pkg.sv
hw/rtl/dls_ram.sv
hw/rtl/dls_ctrl.sv
hw/rtl/dls_mac.sv
hw/rtl/dense_layer_sigmoid_forward.sv
tb/tb.sv
